### design/integer_to_ascii_formatter_unit_assert.svh
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ITOA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itoa assertion failed");
// Next-cycle implication.
`define ITOA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itoa assertion failed");
`else
`define ITOA_ASSERT_IMP(label, clk, rst, ante, cons)
`define ITOA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### design/itoa_pkg.sv
// Shared types, constants, microcode ROM and character lookup for the formatter.
`timescale 1ns / 1ps
package itoa_pkg;

  localparam int ValW = 32;
  localparam int DigW = 40;   // ten BCD digits
  localparam int CntW = 6;
  localparam int StepW = 3;

  localparam logic [CntW-1:0] DABBLE_STEPS = 6'd32;
  localparam logic [CntW-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CntW-1:0] HEX_DIGITS = 6'd8;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;

  // Request format codes.
  localparam logic [1:0] FMT_SDEC = 2'd0;
  localparam logic [1:0] FMT_UDEC = 2'd1;
  localparam logic [1:0] FMT_HEXL = 2'd2;
  localparam logic [1:0] FMT_HEXU = 2'd3;

  // Microcode step addresses.
  localparam logic [StepW-1:0] ST_WAIT = 3'd0;
  localparam logic [StepW-1:0] ST_BRANCH = 3'd1;
  localparam logic [StepW-1:0] ST_HEXLOAD = 3'd2;
  localparam logic [StepW-1:0] ST_DABBLE = 3'd3;
  localparam logic [StepW-1:0] ST_SETCNT = 3'd4;
  localparam logic [StepW-1:0] ST_STRIP = 3'd5;
  localparam logic [StepW-1:0] ST_SIGN = 3'd6;
  localparam logic [StepW-1:0] ST_EMIT = 3'd7;

  typedef enum logic [2:0] {
    UA_ACCEPT,
    UA_NONE,
    UA_HEXLOAD,
    UA_DABBLE,
    UA_SETCNT,
    UA_STRIP,
    UA_SIGN,
    UA_EMIT
  } uc_act_t;

  typedef enum logic [2:0] {
    UC_NEXT,
    UC_ALWAYS,
    UC_NOVALID,
    UC_DEC,
    UC_CNT_NE1,
    UC_STRIP_MORE
  } uc_cond_t;

  typedef struct packed {
    uc_act_t          act;
    uc_cond_t         cond;
    logic [StepW-1:0] target;
  } uc_word_t;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_LOAD,
    DP_HEX,
    DP_DABBLE,
    DP_SHIFT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [ValW-1:0] load_val;
  } dp_ctrl_t;

  // Control store: one word per step.
  function automatic uc_word_t uc_rom(input logic [StepW-1:0] step);
    uc_word_t w;
    case (step)
      ST_WAIT:    w = '{UA_ACCEPT,  UC_NOVALID,    ST_WAIT};
      ST_BRANCH:  w = '{UA_NONE,    UC_DEC,        ST_DABBLE};
      ST_HEXLOAD: w = '{UA_HEXLOAD, UC_ALWAYS,     ST_SETCNT};
      ST_DABBLE:  w = '{UA_DABBLE,  UC_CNT_NE1,    ST_DABBLE};
      ST_SETCNT:  w = '{UA_SETCNT,  UC_NEXT,       ST_WAIT};
      ST_STRIP:   w = '{UA_STRIP,   UC_STRIP_MORE, ST_STRIP};
      ST_SIGN:    w = '{UA_SIGN,    UC_NEXT,       ST_WAIT};
      ST_EMIT:    w = '{UA_EMIT,    UC_CNT_NE1,    ST_EMIT};
      default:    w = '{UA_NONE,    UC_ALWAYS,     ST_WAIT};
    endcase
    return w;
  endfunction

  // Digit nibble to ASCII.
  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    if (nib < 4'd10) begin
      digit_char = ASCII_ZERO + {4'b0, nib};
    end else begin
      base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
      digit_char = base + {4'b0, nib} - 8'd10;
    end
  endfunction

endpackage

### design/itoa_dpath.sv
// Digit datapath: binary shift register, BCD register, hex load, double dabble and nibble shift.
`timescale 1ns / 1ps
module itoa_dpath (
  input  logic                    clk,
  input  itoa_pkg::dp_ctrl_t      ctrl,
  output logic [3:0]              top_nib
);

  logic [itoa_pkg::ValW-1:0] bin;
  logic [itoa_pkg::DigW-1:0] dig;
  logic [itoa_pkg::DigW-1:0] adj;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < itoa_pkg::DigW / 4; i++) begin
      adj[i*4 +: 4] = (dig[i*4 +: 4] >= 4'd5) ? dig[i*4 +: 4] + 4'd3 : dig[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      itoa_pkg::DP_LOAD: begin
        bin <= ctrl.load_val;
        dig <= '0;
      end
      itoa_pkg::DP_HEX: dig <= {bin, 8'b0};
      itoa_pkg::DP_DABBLE: {dig, bin} <= {adj[itoa_pkg::DigW-2:0], bin, 1'b0};
      itoa_pkg::DP_SHIFT: dig <= {dig[itoa_pkg::DigW-5:0], 4'b0};
      default: ;
    endcase
  end

  assign top_nib = dig[itoa_pkg::DigW-1 -: 4];

endmodule

### design/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: microcode sequencer and output register.
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_unit_assert.svh"
// Usage:
//   Input channel (in_valid/in_ready, req_type, value) carries one request: a 32-bit
//   word and a format (signed decimal, unsigned decimal, hex lower, hex upper).
//   Output channel (out_valid/out_ready, char_code, last_char) returns the text one
//   ASCII character per transfer, most significant first; last_char marks the end.
//   Leading zeros are dropped, zero prints "0", negative signed values get '-'.
// Timing:
//   An 8-step microprogram drives one shared datapath. Decimal requests run the
//   double-dabble loop over all 32 bits (one bit per cycle); hex requests load the
//   word as nibbles. Then up to 9 leading zero digits are dropped, one nibble per
//   cycle, and each character leaves at one per cycle while the output is not
//   stalled. Each dropped zero replaces an emit step, so with no stalls a request
//   of a given format takes the same time to the next wait step, whatever the text length.
//   in_ready is high only in the wait step, so one request is in flight at a time;
//   a new request is taken while the final character still sits in the output reg.
// Stalls and reset:
//   When the output register is full and out_ready is low, the sequencer holds its
//   sign or emit step; nothing is dropped. rst (synchronous) returns the sequencer
//   to the wait step and empties the output register.
module integer_to_ascii_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  char_code,
  output logic        last_char
);

  // sequencer state
  logic [itoa_pkg::StepW-1:0] step, step_next;
  logic [itoa_pkg::CntW-1:0]  cnt, cnt_next;
  logic                       neg, is_hex, upper;
  logic                       neg_next, is_hex_next, upper_next;

  // output register loads
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_last;

  itoa_pkg::uc_word_t uw;
  itoa_pkg::dp_ctrl_t dctrl;
  logic [3:0]         top_nib;
  logic               slot_free;
  logic               cond_true;
  logic               stall;
  logic               strip_more;
  logic [31:0]        mag;

  itoa_dpath u_dpath (
    .clk     (clk),
    .ctrl    (dctrl),
    .top_nib (top_nib)
  );

  assign slot_free  = !out_valid || out_ready;
  assign strip_more = (top_nib == 4'd0) && (cnt != 6'd1);
  assign in_ready   = (step == itoa_pkg::ST_WAIT);
  // two's complement magnitude; 0x80000000 maps onto itself, read as unsigned
  assign mag = (req_type == itoa_pkg::FMT_SDEC && value[31]) ? (~value + 32'd1) : value;

  always_comb begin
    uw          = itoa_pkg::uc_rom(step);
    cnt_next    = cnt;
    neg_next    = neg;
    is_hex_next = is_hex;
    upper_next  = upper;
    emit        = 1'b0;
    emit_char   = itoa_pkg::ASCII_ZERO;
    emit_last   = 1'b0;
    stall       = 1'b0;
    dctrl.op       = itoa_pkg::DP_HOLD;
    dctrl.load_val = mag;

    case (uw.cond)
      itoa_pkg::UC_NEXT:       cond_true = 1'b0;
      itoa_pkg::UC_ALWAYS:     cond_true = 1'b1;
      itoa_pkg::UC_NOVALID:    cond_true = !in_valid;
      itoa_pkg::UC_DEC:        cond_true = !is_hex;
      itoa_pkg::UC_CNT_NE1:    cond_true = (cnt != 6'd1);
      itoa_pkg::UC_STRIP_MORE: cond_true = strip_more;
      default:                 cond_true = 1'b0;
    endcase

    case (uw.act)
      itoa_pkg::UA_ACCEPT: begin
        if (in_valid) begin
          dctrl.op    = itoa_pkg::DP_LOAD;
          cnt_next    = itoa_pkg::DABBLE_STEPS;
          neg_next    = (req_type == itoa_pkg::FMT_SDEC) && value[31];
          is_hex_next = (req_type == itoa_pkg::FMT_HEXL) || (req_type == itoa_pkg::FMT_HEXU);
          upper_next  = (req_type == itoa_pkg::FMT_HEXU);
        end
      end
      itoa_pkg::UA_HEXLOAD: dctrl.op = itoa_pkg::DP_HEX;
      itoa_pkg::UA_DABBLE: begin
        dctrl.op = itoa_pkg::DP_DABBLE;
        cnt_next = cnt - 6'd1;
      end
      itoa_pkg::UA_SETCNT: cnt_next = is_hex ? itoa_pkg::HEX_DIGITS : itoa_pkg::DEC_DIGITS;
      itoa_pkg::UA_STRIP: begin
        if (strip_more) begin
          dctrl.op = itoa_pkg::DP_SHIFT;
          cnt_next = cnt - 6'd1;
        end
      end
      itoa_pkg::UA_SIGN: begin
        if (neg) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_char = itoa_pkg::ASCII_MINUS;
          end else begin
            stall = 1'b1;
          end
        end
      end
      itoa_pkg::UA_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = itoa_pkg::digit_char(top_nib, upper);
          emit_last = (cnt == 6'd1);
          dctrl.op  = itoa_pkg::DP_SHIFT;
          cnt_next  = cnt - 6'd1;
        end else begin
          stall = 1'b1;
        end
      end
      default: ;
    endcase

    if (stall) begin
      step_next = step;
    end else if (cond_true) begin
      step_next = uw.target;
    end else begin
      step_next = step + 3'd1;   // emit step wraps to wait
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= itoa_pkg::ST_WAIT;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    neg    <= neg_next;
    is_hex <= is_hex_next;
    upper  <= upper_next;
    if (emit) begin
      char_code <= emit_char;
      last_char <= emit_last;
    end
  end

  // accepted request always moves on to the format branch
  `ITOA_ASSERT_NXT(a_accept_branch, clk, rst, in_valid && in_ready, step == itoa_pkg::ST_BRANCH)
  // the emit loop never runs with an empty digit count or more than ten digits
  `ITOA_ASSERT_IMP(a_emit_cnt, clk, rst, step == itoa_pkg::ST_EMIT, cnt != 6'd0 && cnt <= 6'd10)
  // a minus sign is never the end of the text
  `ITOA_ASSERT_IMP(a_sign_not_last, clk, rst, out_valid && char_code == itoa_pkg::ASCII_MINUS,
                   !last_char)

endmodule

### tb/sv/integer_to_ascii_formatter_unit_test.sv
// Testbench for the integer to ASCII formatter: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module integer_to_ascii_formatter_unit_test;

  // One request as the driver presents it.
  typedef struct packed {
    logic [1:0]  fmt;
    logic [31:0] word;
  } format_request_t;

  // One character as the output channel should carry it.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  localparam int RANDOM_REQUESTS = 147;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PERCENT = 34;
  // Window of cycles in which neither side idles or stalls.
  localparam int STEADY_FROM = 3000;
  localparam int STEADY_TO = 8000;
  // Wait well past the longest request at the end.
  localparam int DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = itoa_pkg::FMT_SDEC;
  logic [31:0] value = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  char_code;
  logic        last_char;

  integer_to_ascii_formatter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last_char (last_char)
  );

  format_request_t pending_requests[$];   // filled up front, drained by the driver
  text_char_t      expected_text[$];      // characters predicted, not yet seen
  format_request_t next_request;
  text_char_t      want;
  logic            in_fire;               // request taken at the latest rising edge
  int              cycle_count = 0;
  int              fail_count = 0;
  logic            steady;
  logic            timed_out;

  assign steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);
  assign timed_out = (cycle_count >= CYCLE_LIMIT);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Predictor: builds the text of one word, most significant character first,
  // and appends it to the expected characters with the final one flagged.
  function automatic void predict_text(input logic [1:0] fmt, input logic [31:0] word);
    logic [7:0]  digits[$];
    logic [31:0] mag;
    logic [31:0] rem;
    logic [3:0]  nib;
    logic [7:0]  letter_base;
    logic        negative;
    text_char_t  ch;
    negative = 1'b0;
    mag = word;
    if (fmt == itoa_pkg::FMT_HEXL || fmt == itoa_pkg::FMT_HEXU) begin
      letter_base = (fmt == itoa_pkg::FMT_HEXU) ? itoa_pkg::ASCII_UPPER_A
                                                : itoa_pkg::ASCII_LOWER_A;
      // Leading zero nibbles drop out because the loop stops once the rest is zero.
      do begin
        nib = mag[3:0];
        if (nib < 4'd10) begin
          digits.push_front(itoa_pkg::ASCII_ZERO + {4'b0, nib});
        end else begin
          digits.push_front(letter_base + {4'b0, nib} - 8'd10);
        end
        mag = mag >> 4;
      end while (mag != 32'd0);
    end else begin
      // Two's complement negate as an unsigned word; the most negative value
      // maps onto itself, which is exactly its magnitude.
      if (fmt == itoa_pkg::FMT_SDEC && word[31]) begin
        negative = 1'b1;
        mag = ~word + 32'd1;
      end
      do begin
        rem = mag % 32'd10;
        digits.push_front(itoa_pkg::ASCII_ZERO + rem[7:0]);
        mag = mag / 32'd10;
      end while (mag != 32'd0);
      if (negative) begin
        digits.push_front(itoa_pkg::ASCII_MINUS);
      end
    end
    for (int i = 0; i < digits.size(); i++) begin
      ch.code = digits[i];
      ch.last = (i == digits.size() - 1);
      expected_text.push_back(ch);
    end
  endfunction

  // Random word with a spread of digit counts: full range, short values,
  // a full word shifted down, and values near powers of ten and of two.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          pick;
    pick = $urandom_range(5);
    case (pick)
      0, 1: w = $urandom;
      2: w = $urandom_range(999);
      3: w = $urandom >> $urandom_range(31);
      4: begin
        w = 32'd1;
        repeat ($urandom_range(9)) w = w * 32'd10;
        w = w + $urandom_range(2) - 32'd1;
      end
      default: w = (32'd1 << $urandom_range(31)) + $urandom_range(2) - 32'd1;
    endcase
    return w;
  endfunction

  function automatic void queue_request(input logic [1:0] fmt, input logic [31:0] word);
    format_request_t r;
    r.fmt = fmt;
    r.word = word;
    pending_requests.push_back(r);
  endfunction

  // Driver: inputs change on the falling edge. A request held on the bus is
  // kept until the rising edge that takes it; then the next one, or an idle gap.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_fire) begin
        if (pending_requests.size() != 0 &&
            (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          next_request = pending_requests.pop_front();
          in_valid <= 1'b1;
          req_type <= next_request.fmt;
          value    <= next_request.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Monitor: sample both channels on the rising edge. A taken request adds its
  // text to the expected characters; each character out is checked against
  // the oldest one waiting.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_text(req_type, value);
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: unexpected character: expected none, actual code %h last %b",
                   $time, char_code, last_char);
        end else begin
          want = expected_text.pop_front();
          if (char_code !== want.code) begin
            fail_count = fail_count + 1;
            $display("%0t: char_code mismatch: expected %h, actual %h",
                     $time, want.code, char_code);
          end
          if (last_char !== want.last) begin
            fail_count = fail_count + 1;
            $display("%0t: last_char mismatch: expected %b, actual %b",
                     $time, want.last, last_char);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;

    // Zero in every format: a lone "0" with no sign.
    queue_request(itoa_pkg::FMT_SDEC, 32'd0);
    queue_request(itoa_pkg::FMT_UDEC, 32'd0);
    queue_request(itoa_pkg::FMT_HEXL, 32'd0);
    queue_request(itoa_pkg::FMT_HEXU, 32'd0);
    // Most negative word, signed and unsigned.
    queue_request(itoa_pkg::FMT_SDEC, 32'h8000_0000);
    queue_request(itoa_pkg::FMT_UDEC, 32'h8000_0000);
    // All ones in every format; -1 when signed, ten digits unsigned.
    queue_request(itoa_pkg::FMT_SDEC, 32'hFFFF_FFFF);
    queue_request(itoa_pkg::FMT_UDEC, 32'hFFFF_FFFF);
    queue_request(itoa_pkg::FMT_HEXL, 32'hFFFF_FFFF);
    queue_request(itoa_pkg::FMT_HEXU, 32'hFFFF_FFFF);
    queue_request(itoa_pkg::FMT_SDEC, 32'h7FFF_FFFF);
    queue_request(itoa_pkg::FMT_UDEC, 32'h7FFF_FFFF);
    // Hex with trailing and interior zero nibbles, both letter cases.
    queue_request(itoa_pkg::FMT_HEXL, 32'h1000_0000);
    queue_request(itoa_pkg::FMT_HEXU, 32'h0000_0010);
    queue_request(itoa_pkg::FMT_HEXL, 32'hA0B0_C0D0);
    queue_request(itoa_pkg::FMT_HEXU, 32'hA0B0_C0D0);
    queue_request(itoa_pkg::FMT_HEXL, 32'h0DEA_DBEF);
    queue_request(itoa_pkg::FMT_HEXU, 32'h0DEA_DBEF);
    // Digit count steps in decimal.
    queue_request(itoa_pkg::FMT_SDEC, 32'd1);
    queue_request(itoa_pkg::FMT_UDEC, 32'd9);
    queue_request(itoa_pkg::FMT_UDEC, 32'd10);
    queue_request(itoa_pkg::FMT_UDEC, 32'd1000000000);
    queue_request(itoa_pkg::FMT_SDEC, 32'hFFFF_FFF6);   // -10

    repeat (RANDOM_REQUESTS) begin
      queue_request(2'($urandom_range(3)), random_word());
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every request to go out and every character to come back.
    while (!timed_out &&
           (pending_requests.size() != 0 || in_valid || expected_text.size() != 0)) begin
      @(posedge clk);
    end
    if (!timed_out) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (timed_out) begin
      $display("TB_ERROR");
    end else if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### integer_to_ascii_formatter_unit.f
+incdir+design
design/itoa_pkg.sv
design/itoa_dpath.sv
design/integer_to_ascii_formatter_unit.sv
tb/sv/integer_to_ascii_formatter_unit_test.sv
